>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the sliding median filter window block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When ante holds, cons must hold in the next cycle.
`define ASSERT_IMPLIES_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg
// Constants and word types shared by the sliding median filter modules.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int DATA_W     = 32;
  localparam int WINDOW     = 5;
  localparam int HALF_W     = WINDOW / 2;
  localparam int HIST_DEPTH = 2 * HALF_W;
  localparam int SPAN       = HIST_DEPTH + 1;
  localparam int HIST_SLOTS = (HIST_DEPTH > 0) ? HIST_DEPTH : 1;
  // counts, positions and ranks: 0 .. SPAN
  localparam int CNT_W      = $clog2(SPAN + 1);
  localparam int EXT_W      = CNT_W + 1;

  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic              is_final;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] median_value;
    logic              end_of_sequence;
  } out_word_t;

  // one window to reduce: candidate samples plus membership mask
  typedef struct packed {
    logic [SPAN-1:0][DATA_W-1:0] vals;
    logic [SPAN-1:0]             mask;
    logic                        eos;
  } win_word_t;

  // window with the sorted position of every member
  typedef struct packed {
    logic [SPAN-1:0][DATA_W-1:0] vals;
    logic [SPAN-1:0]             mask;
    logic [SPAN-1:0][CNT_W-1:0]  ranks;
    logic [CNT_W-1:0]            cnt;
    logic                        eos;
  } rank_word_t;

endpackage

>>> rtl/sliding_median_filter.sv
// Each result word is registered in the window issue, rank and output registers in turn.
// Throughput: one sample word per cycle unless stalled; a final word occupies the window
//   issue register until every flushed result has issued, and stalls the input meanwhile.
// Each pipeline stage holds its word under stall; while a result waits, input keeps flowing
//   only until the window and rank stages behind the output are full.
// Reset (rst_n low, synchronous): sequence counter and all stage valids cleared; history
//   and payload registers are not reset.
// ----------------------------------------------------------------------------
// sliding_median_filter
// Centered sliding median over unsigned Q16.16 samples, window clipped at both
// ends of a sequence, even-sized windows averaged.
// ----------------------------------------------------------------------------
module sliding_median_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  smf_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output smf_pkg::out_word_t out_data
);

  // Pipeline:
  //   smf_window - history of the last 2*HALF_W samples plus a job register that
  //                holds one snapshot and walks its window centers. A normal sample
  //                yields the window centered HALF_W positions back; a final sample
  //                yields every pending center up to its own position.
  //   smf_rank   - all-pairs compare gives each member its sorted position.
  //   smf_select - pulls ranks (cnt-1)/2 and cnt/2, adds them in 33 bits, halves.

  logic                win_valid;
  logic                win_stall;
  smf_pkg::win_word_t  win_data;
  logic                rank_valid;
  logic                rank_stall;
  smf_pkg::rank_word_t rank_data;

  smf_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .win_valid (win_valid),
    .win_stall (win_stall),
    .win_data  (win_data)
  );

  smf_rank u_rank (
    .clk        (clk),
    .rst_n      (rst_n),
    .win_valid  (win_valid),
    .win_stall  (win_stall),
    .win_data   (win_data),
    .rank_valid (rank_valid),
    .rank_stall (rank_stall),
    .rank_data  (rank_data)
  );

  // output register: result word holds here under out_stall
  smf_select u_select (
    .clk        (clk),
    .rst_n      (rst_n),
    .rank_valid (rank_valid),
    .rank_stall (rank_stall),
    .rank_data  (rank_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

>>> rtl/smf_window.sv
// ----------------------------------------------------------------------------
// smf_window
// Sample history and window issue: one window word per cycle while win_stall is low, several on flush.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smf_window (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  smf_pkg::in_word_t  in_data,
  output logic               win_valid,
  input  logic               win_stall,
  output smf_pkg::win_word_t win_data
);

  logic [smf_pkg::DATA_W-1:0]                    hist_r [smf_pkg::HIST_SLOTS];
  logic [smf_pkg::CNT_W-1:0]                     seen_r;
  logic                                          job_v_r;
  logic [smf_pkg::SPAN-1:0][smf_pkg::DATA_W-1:0] job_buf_r;
  logic [smf_pkg::CNT_W-1:0]                     job_len_r;
  logic [smf_pkg::CNT_W-1:0]                     job_c_r;
  logic [smf_pkg::CNT_W-1:0]                     job_last_r;
  logic                                          job_fin_r;

  logic [smf_pkg::SPAN-1:0][smf_pkg::DATA_W-1:0] job_buf_nxt;
  logic [smf_pkg::CNT_W-1:0]                     job_first_nxt;
  logic [smf_pkg::CNT_W-1:0]                     job_last_nxt;
  logic [smf_pkg::EXT_W-1:0]                     c_ext;
  logic [smf_pkg::EXT_W-1:0]                     k_ext;
  logic                                          take;
  logic                                          job_end;
  logic                                          in_acc;
  logic                                          load;

  assign take     = job_v_r && !win_stall;
  assign job_end  = take && (job_c_r == job_last_r);
  assign in_stall = job_v_r && !job_end;
  assign in_acc   = in_valid && !in_stall;
  assign load     = in_acc &&
                    (in_data.is_final || (seen_r >= smf_pkg::CNT_W'(smf_pkg::HALF_W)));

  // snapshot of the sequence so far plus the new sample
  always_comb begin
    for (int k = 0; k < smf_pkg::SPAN; k++) begin
      if (k < smf_pkg::HIST_DEPTH && seen_r != smf_pkg::CNT_W'(k)) begin
        job_buf_nxt[k] = hist_r[(k < smf_pkg::HIST_SLOTS) ? k : 0];
      end else begin
        job_buf_nxt[k] = in_data.sample;
      end
    end
    if (in_data.is_final) begin
      job_last_nxt  = seen_r;
      job_first_nxt = (seen_r >= smf_pkg::CNT_W'(smf_pkg::HALF_W)) ?
                      seen_r - smf_pkg::CNT_W'(smf_pkg::HALF_W) : '0;
    end else begin
      job_last_nxt  = seen_r - smf_pkg::CNT_W'(smf_pkg::HALF_W);
      job_first_nxt = seen_r - smf_pkg::CNT_W'(smf_pkg::HALF_W);
    end
  end

  // window around the current center, clipped to the sequence
  always_comb begin
    c_ext         = {1'b0, job_c_r};
    k_ext         = '0;
    win_data.vals = job_buf_r;
    win_data.eos  = job_fin_r && (job_c_r == job_last_r);
    for (int k = 0; k < smf_pkg::SPAN; k++) begin
      k_ext            = smf_pkg::EXT_W'(k);
      win_data.mask[k] = (k_ext + smf_pkg::EXT_W'(smf_pkg::HALF_W) >= c_ext) &&
                         (k_ext <= c_ext + smf_pkg::EXT_W'(smf_pkg::HALF_W)) &&
                         (smf_pkg::CNT_W'(k) < job_len_r);
    end
  end

  assign win_valid = job_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      job_v_r <= 1'b0;
    end else begin
      if (load) begin
        job_v_r <= 1'b1;
      end else if (job_end) begin
        job_v_r <= 1'b0;
      end
      if (in_acc) begin
        if (in_data.is_final) begin
          seen_r <= '0;
        end else if (seen_r < smf_pkg::CNT_W'(smf_pkg::HIST_DEPTH)) begin
          seen_r <= seen_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_buf_r  <= job_buf_nxt;
      job_len_r  <= seen_r + 1'b1;
      job_c_r    <= job_first_nxt;
      job_last_r <= job_last_nxt;
      job_fin_r  <= in_data.is_final;
    end else if (take && !job_end) begin
      job_c_r <= job_c_r + 1'b1;
    end
    if (in_acc && !in_data.is_final && smf_pkg::HIST_DEPTH > 0) begin
      for (int k = 0; k < smf_pkg::HIST_SLOTS; k++) begin
        if (seen_r < smf_pkg::CNT_W'(smf_pkg::HIST_DEPTH)) begin
          if (seen_r == smf_pkg::CNT_W'(k)) begin
            hist_r[k] <= in_data.sample;
          end
        end else if (k == smf_pkg::HIST_SLOTS - 1) begin
          hist_r[k] <= in_data.sample;
        end else begin
          hist_r[k] <= hist_r[(k + 1 < smf_pkg::HIST_SLOTS) ? k + 1 : k];
        end
      end
    end
  end

  `ASSERT_IMPLIES_NEXT(a_final_clears, clk, rst_n, in_acc && in_data.is_final, seen_r == '0, "history not cleared after final sample")
  `ASSERT_HOLDS(a_center_range, clk, rst_n, !job_v_r || (job_c_r <= job_last_r), "window center passed last position")
  `ASSERT_IMPLIES_NEXT(a_steady_issue, clk, rst_n, in_acc && (seen_r >= smf_pkg::CNT_W'(smf_pkg::HALF_W)), job_v_r, "filled history gave no window")

endmodule

>>> rtl/smf_rank.sv
// ----------------------------------------------------------------------------
// smf_rank
// Ranks every window member by parallel compares; ties broken by position.
// ----------------------------------------------------------------------------
module smf_rank (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                win_valid,
  output logic                win_stall,
  input  smf_pkg::win_word_t  win_data,
  output logic                rank_valid,
  input  logic                rank_stall,
  output smf_pkg::rank_word_t rank_data
);

  logic                                         rank_v_r;
  smf_pkg::rank_word_t                          rank_r;
  logic [smf_pkg::SPAN-1:0][smf_pkg::CNT_W-1:0] ranks_nxt;
  logic [smf_pkg::CNT_W-1:0]                    cnt_nxt;
  logic                                         acc;

  assign win_stall = rank_v_r && rank_stall;
  assign acc       = win_valid && !win_stall;

  always_comb begin
    cnt_nxt = '0;
    for (int i = 0; i < smf_pkg::SPAN; i++) begin
      cnt_nxt      = cnt_nxt + smf_pkg::CNT_W'(win_data.mask[i]);
      ranks_nxt[i] = '0;
      for (int j = 0; j < smf_pkg::SPAN; j++) begin
        if (win_data.mask[j] &&
            ((win_data.vals[j] < win_data.vals[i]) ||
             (j < i && win_data.vals[j] == win_data.vals[i]))) begin
          ranks_nxt[i] = ranks_nxt[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_v_r <= 1'b0;
    end else if (!win_stall) begin
      rank_v_r <= win_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rank_r.vals  <= win_data.vals;
      rank_r.mask  <= win_data.mask;
      rank_r.ranks <= ranks_nxt;
      rank_r.cnt   <= cnt_nxt;
      rank_r.eos   <= win_data.eos;
    end
  end

  assign rank_valid = rank_v_r;
  assign rank_data  = rank_r;

endmodule

>>> rtl/smf_select.sv
// ----------------------------------------------------------------------------
// smf_select
// Picks the middle member(s) by rank and averages them into the output word.
// ----------------------------------------------------------------------------
module smf_select (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rank_valid,
  output logic                rank_stall,
  input  smf_pkg::rank_word_t rank_data,
  output logic                out_valid,
  input  logic                out_stall,
  output smf_pkg::out_word_t  out_data
);

  logic                       out_v_r;
  smf_pkg::out_word_t         out_r;
  logic [smf_pkg::CNT_W-1:0]  lo_rank;
  logic [smf_pkg::CNT_W-1:0]  hi_rank;
  logic [smf_pkg::DATA_W-1:0] lo_val;
  logic [smf_pkg::DATA_W-1:0] hi_val;
  logic [smf_pkg::DATA_W:0]   sum;
  logic                       acc;

  assign rank_stall = out_v_r && out_stall;
  assign acc        = rank_valid && !rank_stall;

  // odd count: both ranks hit the middle, so the mean is the value itself
  always_comb begin
    lo_rank = (rank_data.cnt - 1'b1) >> 1;
    hi_rank = rank_data.cnt >> 1;
    lo_val  = '0;
    hi_val  = '0;
    for (int i = 0; i < smf_pkg::SPAN; i++) begin
      if (rank_data.mask[i] && rank_data.ranks[i] == lo_rank) begin
        lo_val = lo_val | rank_data.vals[i];
      end
      if (rank_data.mask[i] && rank_data.ranks[i] == hi_rank) begin
        hi_val = hi_val | rank_data.vals[i];
      end
    end
    sum = {1'b0, lo_val} + {1'b0, hi_val};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!rank_stall) begin
      out_v_r <= rank_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_r.median_value    <= sum[smf_pkg::DATA_W:1];
      out_r.end_of_sequence <= rank_data.eos;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
